/* design/mqmf_pkg.sv */
// mqmf_pkg: shared types and constants of the multi-queue message FIFO.
// Operation and status codes, fixed field widths, the per-item action struct.
// No dependencies.
package mqmf_pkg;

   localparam int QID_W    = 3;
   localparam int CSR_W    = 4;
   localparam int FILL_W   = 4;
   localparam int STATUS_W = 2;
   localparam int MSG_PORT_W = 64;

   localparam logic [CSR_W-1:0] DEPTH_RESET = 4'd8;

   typedef enum logic {
      OP_SEND    = 1'b0,
      OP_RECEIVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_BAD_QUEUE = 2'd3
   } status_type;

   // Decision taken for one item, handed from the queue control to the top level
   typedef struct packed {
      status_type          status;
      logic                write_slot;
      logic                read_slot;
      logic [FILL_W-1:0]   fill_count;
   } action_type;

endpackage

/* design/mqmf_ram.sv */
// mqmf_ram: generic single-port RAM with registered read data.
// Parameters set width and depth. No dependencies.
module mqmf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   write_enable,
   input  logic                                   read_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] address,
   input  logic [WIDTH-1:0]                       write_data,
   output logic [WIDTH-1:0]                       read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

/* design/mqmf_ctrl.sv */
// mqmf_ctrl: per-queue write/read indices and occupancy, and the decision
// (done, full, empty, bad queue) for each item. Uses mqmf_pkg.
module mqmf_ctrl #(
   parameter int QUEUE_COUNT     = 4,
   parameter int SLOTS_PER_QUEUE = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  operation,
   input  logic [mqmf_pkg::QID_W-1:0]            queue_id,
   input  logic [mqmf_pkg::CSR_W-1:0]            queue_depth,
   output mqmf_pkg::action_type                  action,
   output logic [((QUEUE_COUNT*SLOTS_PER_QUEUE > 1) ?
                  $clog2(QUEUE_COUNT*SLOTS_PER_QUEUE) : 1)-1:0] slot_addr
);

   localparam int IDX_W  = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
   localparam int CNT_W  = $clog2(SLOTS_PER_QUEUE + 1);
   localparam int Q_W    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int ADDR_W = (QUEUE_COUNT*SLOTS_PER_QUEUE > 1) ?
                           $clog2(QUEUE_COUNT*SLOTS_PER_QUEUE) : 1;

   logic [IDX_W-1:0] write_index_ff [QUEUE_COUNT];
   logic [IDX_W-1:0] write_index_in [QUEUE_COUNT];
   logic [IDX_W-1:0] read_index_ff  [QUEUE_COUNT];
   logic [IDX_W-1:0] read_index_in  [QUEUE_COUNT];
   logic [CNT_W-1:0] occupancy_ff   [QUEUE_COUNT];
   logic [CNT_W-1:0] occupancy_in   [QUEUE_COUNT];

   logic [CNT_W-1:0] eff_depth;
   logic             bad_queue;
   logic [Q_W-1:0]   qidx;
   logic [CNT_W-1:0] occ;
   logic [IDX_W-1:0] widx;
   logic [IDX_W-1:0] ridx;
   mqmf_pkg::action_type act;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] depth);
      logic [CNT_W:0] n;
      n = (CNT_W+1)'(idx) + 1'b1;
      if (n >= (CNT_W+1)'(depth)) begin
         n = '0;
      end
      return n[IDX_W-1:0];
   endfunction

   // raw register keeps its bits; zero acts as one, large values clamp
   always_comb begin
      if (queue_depth == '0) begin
         eff_depth = CNT_W'(1);
      end else if (queue_depth > mqmf_pkg::CSR_W'(SLOTS_PER_QUEUE)) begin
         eff_depth = CNT_W'(SLOTS_PER_QUEUE);
      end else begin
         eff_depth = CNT_W'(queue_depth);
      end
   end

   assign bad_queue = ({1'b0, queue_id} >= (mqmf_pkg::QID_W+1)'(QUEUE_COUNT));
   assign qidx = bad_queue ? '0 : Q_W'(queue_id);
   assign occ  = occupancy_ff[qidx];
   assign widx = write_index_ff[qidx];
   assign ridx = read_index_ff[qidx];

   always_comb begin
      act.status     = mqmf_pkg::STATUS_DONE;
      act.write_slot = 1'b0;
      act.read_slot  = 1'b0;
      act.fill_count = '0;
      if (bad_queue) begin
         act.status = mqmf_pkg::STATUS_BAD_QUEUE;
      end else if (mqmf_pkg::op_type'(operation) == mqmf_pkg::OP_SEND) begin
         if (occ >= eff_depth) begin
            act.status     = mqmf_pkg::STATUS_FULL;
            act.fill_count = mqmf_pkg::FILL_W'(occ);
         end else begin
            act.write_slot = 1'b1;
            act.fill_count = mqmf_pkg::FILL_W'((CNT_W+1)'(occ) + 1'b1);
         end
      end else begin
         if (occ == '0) begin
            act.status = mqmf_pkg::STATUS_EMPTY;
         end else begin
            act.read_slot  = 1'b1;
            act.fill_count = mqmf_pkg::FILL_W'(occ - 1'b1);
         end
      end
   end

   assign action    = act;
   assign slot_addr = ADDR_W'(int'(qidx) * SLOTS_PER_QUEUE +
                              int'(act.write_slot ? widx : ridx));

   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      occupancy_in   = occupancy_ff;
      if (accept && act.write_slot) begin
         write_index_in[qidx] = advance(widx, eff_depth);
         occupancy_in[qidx]   = occ + 1'b1;
      end
      if (accept && act.read_slot) begin
         read_index_in[qidx] = advance(ridx, eff_depth);
         occupancy_in[qidx]  = occ - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            write_index_ff[i] <= '0;
            read_index_ff[i]  <= '0;
            occupancy_ff[i]   <= '0;
         end
      end else begin
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         occupancy_ff   <= occupancy_in;
      end
   end

endmodule

/* design/multi_queue_message_fifo.sv */
// multi_queue_message_fifo: top level; depth register, slot RAM, result registers.
// Uses mqmf_pkg, mqmf_ctrl and mqmf_ram.
//
// One send or receive is taken per clock (start high, busy low; busy is high only
// while reset is asserted). Each item gives exactly one result, registered at the
// transfer edge, held for one cycle and marked by rsp_strobe; the receiver
// cannot stall, so results must be taken as they appear. The registered read of
// the slot RAM, a single port that serves the one write or read of each item, is
// captured at the same edge as the result registers. Slot contents have no reset
// and are never cleared; after reset the block takes items at once. csr_write_data
// sets one depth for all queues; zero acts as one, values above the slot count clamp.
module multi_queue_message_fifo #(
   parameter int QUEUE_COUNT     = 4,
   parameter int SLOTS_PER_QUEUE = 8,
   parameter int MESSAGE_BYTES   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [mqmf_pkg::QID_W-1:0]        req_queue_id,
   input  logic [mqmf_pkg::MSG_PORT_W-1:0]   req_message_in,
   output logic                              rsp_strobe,
   output logic [mqmf_pkg::STATUS_W-1:0]     rsp_status,
   output logic [mqmf_pkg::MSG_PORT_W-1:0]   rsp_message_out,
   output logic [mqmf_pkg::FILL_W-1:0]       rsp_fill_count,
   input  logic                              csr_write_enable,
   input  logic [mqmf_pkg::CSR_W-1:0]        csr_write_data
);

   localparam int MSG_W  = 8 * MESSAGE_BYTES;
   localparam int SLOTS  = QUEUE_COUNT * SLOTS_PER_QUEUE;
   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [mqmf_pkg::CSR_W-1:0]  queue_depth_ff;
   logic                        accept;
   mqmf_pkg::action_type        action;
   logic [ADDR_W-1:0]           slot_addr;
   logic [MSG_W-1:0]            slot_rdata;

   logic                        rsp_strobe_ff;
   mqmf_pkg::status_type        rsp_status_ff;
   logic [mqmf_pkg::FILL_W-1:0] rsp_fill_ff;
   logic                        rsp_has_msg_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_depth_ff <= mqmf_pkg::DEPTH_RESET;
      end else if (csr_write_enable) begin
         queue_depth_ff <= csr_write_data;
      end
   end

   mqmf_ctrl #(
      .QUEUE_COUNT     (QUEUE_COUNT),
      .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .queue_id    (req_queue_id),
      .queue_depth (queue_depth_ff),
      .action      (action),
      .slot_addr   (slot_addr)
   );

   // only the low MESSAGE_BYTES bytes are stored
   mqmf_ram #(
      .WIDTH (MSG_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock        (clock),
      .write_enable (accept && action.write_slot),
      .read_enable  (accept && action.read_slot),
      .address      (slot_addr),
      .write_data   (req_message_in[MSG_W-1:0]),
      .read_data    (slot_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff  <= 1'b0;
         rsp_has_msg_ff <= 1'b0;
      end else begin
         rsp_strobe_ff  <= accept;
         rsp_has_msg_ff <= accept && action.read_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= action.status;
         rsp_fill_ff   <= action.fill_count;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fill_count  = rsp_fill_ff;
   // RAM read data lines up with the result registers
   assign rsp_message_out = rsp_has_msg_ff ? mqmf_pkg::MSG_PORT_W'(slot_rdata) : '0;

endmodule

/* test/tb.sv */
// tb: self-checking bench for multi_queue_message_fifo, random plus directed traffic.
// Depends on mqmf_pkg and the block RTL; a scoreboard class predicts every reply in order.
module tb;

   localparam int QUEUES      = 4;
   localparam int SLOTS       = 8;
   localparam int PHASE_ITEMS = 70;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      mqmf_pkg::status_type                status;
      logic [mqmf_pkg::MSG_PORT_W-1:0]     message;
      logic [mqmf_pkg::FILL_W-1:0]         fill;
   } reply_type;

   class fifo_scoreboard;
      logic [mqmf_pkg::CSR_W-1:0]      depth_csr;
      logic [2:0]                      wr_ptr[QUEUES];
      logic [2:0]                      rd_ptr[QUEUES];
      logic [mqmf_pkg::FILL_W-1:0]     held[QUEUES];
      logic [mqmf_pkg::MSG_PORT_W-1:0] slot_data[QUEUES*SLOTS];
      bit                              slot_written[QUEUES*SLOTS];
      reply_type                       pending_replies[$];
      int                              failures;

      function new();
         depth_csr = mqmf_pkg::DEPTH_RESET;
         failures = 0;
         for (int q = 0; q < QUEUES; q++) begin
            wr_ptr[q] = '0;
            rd_ptr[q] = '0;
            held[q] = '0;
         end
         for (int a = 0; a < QUEUES*SLOTS; a++) begin
            slot_data[a] = '0;
            slot_written[a] = 1'b0;
         end
      endfunction

      function void load_depth(logic [mqmf_pkg::CSR_W-1:0] value);
         depth_csr = value;
      endfunction

      // zero acts as one, anything above the slot count clamps
      function int effective_depth();
         int d;
         d = int'(depth_csr);
         if (d == 0) d = 1;
         if (d > SLOTS) d = SLOTS;
         return d;
      endfunction

      function logic [2:0] next_index(logic [2:0] idx, int d);
         int n;
         n = int'(idx) + 1;
         if (n >= d) n = 0;
         return 3'(n);
      endfunction

      // false when a receive on qid would hit a slot never written since reset
      function bit read_is_defined(logic [2:0] qid);
         if (qid >= QUEUES || held[qid] == 0) return 1'b1;
         return slot_written[int'(qid)*SLOTS + int'(rd_ptr[qid])];
      endfunction

      function void note_request(mqmf_pkg::op_type op, logic [2:0] qid,
                                 logic [mqmf_pkg::MSG_PORT_W-1:0] msg);
         reply_type r;
         int d;
         int a;
         r.status = mqmf_pkg::STATUS_DONE;
         r.message = '0;
         r.fill = '0;
         if (qid >= QUEUES) begin
            r.status = mqmf_pkg::STATUS_BAD_QUEUE;
         end else begin
            d = effective_depth();
            if (op == mqmf_pkg::OP_SEND) begin
               if (held[qid] >= d) begin
                  r.status = mqmf_pkg::STATUS_FULL;
               end else begin
                  a = int'(qid)*SLOTS + int'(wr_ptr[qid]);
                  slot_data[a] = msg;
                  slot_written[a] = 1'b1;
                  wr_ptr[qid] = next_index(wr_ptr[qid], d);
                  held[qid] = held[qid] + 1'b1;
               end
            end else begin
               if (held[qid] == 0) begin
                  r.status = mqmf_pkg::STATUS_EMPTY;
               end else begin
                  a = int'(qid)*SLOTS + int'(rd_ptr[qid]);
                  r.message = slot_data[a];
                  rd_ptr[qid] = next_index(rd_ptr[qid], d);
                  held[qid] = held[qid] - 1'b1;
               end
            end
            r.fill = held[qid];
         end
         pending_replies.push_back(r);
      endfunction

      function void check_response(logic [mqmf_pkg::STATUS_W-1:0] st,
                                   logic [mqmf_pkg::MSG_PORT_W-1:0] msg,
                                   logic [mqmf_pkg::FILL_W-1:0] fill);
         reply_type r;
         if (pending_replies.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected reply: status %0d message %h fill %0d", st, msg, fill);
            return;
         end
         r = pending_replies.pop_front();
         if (st !== r.status || msg !== r.message || fill !== r.fill) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display({"reply mismatch: expected status %0d message %h fill %0d, ",
                         "got status %0d message %h fill %0d"},
                        r.status, r.message, r.fill, st, msg, fill);
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic                            req_operation;
   logic [mqmf_pkg::QID_W-1:0]      req_queue_id;
   logic [mqmf_pkg::MSG_PORT_W-1:0] req_message_in;
   logic                            rsp_strobe;
   logic [mqmf_pkg::STATUS_W-1:0]   rsp_status;
   logic [mqmf_pkg::MSG_PORT_W-1:0] rsp_message_out;
   logic [mqmf_pkg::FILL_W-1:0]     rsp_fill_count;
   logic                            csr_write_enable;
   logic [mqmf_pkg::CSR_W-1:0]      csr_write_data;

   fifo_scoreboard sb;
   int quiet_cycles = 0;

   multi_queue_message_fifo DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_queue_id    (req_queue_id),
      .req_message_in  (req_message_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_message_out (rsp_message_out),
      .rsp_fill_count  (rsp_fill_count),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // reply checking and stall watchdog
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_response(rsp_status, rsp_message_out, rsp_fill_count);
      if ((start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // start stays high; the caller lowers it by pausing or draining
   task automatic issue(mqmf_pkg::op_type op, logic [mqmf_pkg::QID_W-1:0] qid,
                        logic [mqmf_pkg::MSG_PORT_W-1:0] msg);
      start <= 1'b1;
      req_operation <= op;
      req_queue_id <= qid;
      req_message_in <= msg;
      do @(posedge clock); while (busy);
      sb.note_request(op, qid, msg);
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_depth(logic [mqmf_pkg::CSR_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.load_depth(value);
   endtask

   initial begin
      logic [mqmf_pkg::CSR_W-1:0]      depth_plan[12];
      mqmf_pkg::op_type                op;
      logic [mqmf_pkg::QID_W-1:0]      qid;
      logic [mqmf_pkg::MSG_PORT_W-1:0] msg;
      int                              idle_pct;
      int                              send_pct;

      depth_plan = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd8,
                     4'd5, 4'd9, 4'd2, 4'd6, 4'd4, 4'd7};
      sb = new();
      start <= 1'b0;
      req_operation <= 1'b0;
      req_queue_id <= '0;
      req_message_in <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: depth two, empty/full/bad queue, payload extremes
      write_depth(4'd2);
      issue(mqmf_pkg::OP_RECEIVE, 3'd0, '0);
      issue(mqmf_pkg::OP_SEND,    3'd4, 64'h0123_4567_89ab_cdef);
      issue(mqmf_pkg::OP_RECEIVE, 3'd7, '1);
      issue(mqmf_pkg::OP_SEND,    3'd0, '0);
      issue(mqmf_pkg::OP_SEND,    3'd0, '1);
      issue(mqmf_pkg::OP_SEND,    3'd0, 64'h0123_4567_89ab_cdef);
      issue(mqmf_pkg::OP_RECEIVE, 3'd0, '0);
      issue(mqmf_pkg::OP_RECEIVE, 3'd0, '0);
      issue(mqmf_pkg::OP_RECEIVE, 3'd0, '0);
      issue(mqmf_pkg::OP_SEND,    3'd3, 64'h8000_0000_0000_0001);
      issue(mqmf_pkg::OP_RECEIVE, 3'd5, '1);
      issue(mqmf_pkg::OP_RECEIVE, 3'd3, '1);
      issue(mqmf_pkg::OP_SEND,    3'd1, '1);
      issue(mqmf_pkg::OP_SEND,    3'd2, 64'ha5a5_5a5a_f0f0_0f0f);
      issue(mqmf_pkg::OP_RECEIVE, 3'd1, '0);
      issue(mqmf_pkg::OP_RECEIVE, 3'd2, '0);

      // random phases; depth changes land on non-empty queues on purpose
      for (int ph = 0; ph < 12; ph++) begin
         write_depth(depth_plan[ph]);
         idle_pct = (ph < 4) ? 28 : (ph < 8) ? 74 : 0;
         send_pct = 50;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 16 == 0) begin
               case ($urandom_range(0, 2))
                  0: send_pct = 15;
                  1: send_pct = 50;
                  default: send_pct = 85;
               endcase
            end
            // each cycle is idle with probability idle_pct
            while ($urandom_range(0, 99) < idle_pct)
               pause(1);
            if ($urandom_range(0, 7) == 0)
               qid = mqmf_pkg::QID_W'($urandom_range(QUEUES, 7));
            else
               qid = mqmf_pkg::QID_W'($urandom_range(0, QUEUES-1));
            op = ($urandom_range(0, 99) < send_pct) ? mqmf_pkg::OP_SEND
                                                    : mqmf_pkg::OP_RECEIVE;
            // never read a slot that was not written since reset
            if (op == mqmf_pkg::OP_RECEIVE && !sb.read_is_defined(qid))
               op = mqmf_pkg::OP_SEND;
            case ($urandom_range(0, 9))
               0: msg = '0;
               1: msg = '1;
               default: msg = {$urandom, $urandom};
            endcase
            issue(op, qid, msg);
         end
      end

      drain();
      if (sb.failures == 0 && sb.pending_replies.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
design/mqmf_pkg.sv
design/mqmf_ram.sv
design/mqmf_ctrl.sv
design/multi_queue_message_fifo.sv
test/tb.sv
